/* rtl/adcp_pkg.sv */
`default_nettype none

package adcp_pkg;

	// Fraction digits kept; the weight table has six entries.
	localparam int FRAC_DIGITS = 4;
	localparam int FRAC_LIMIT  = (FRAC_DIGITS < 6) ? FRAC_DIGITS : 6;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_O_UP   = 8'h4F;
	localparam logic [7:0] CH_O_LOW  = 8'h6F;
	localparam logic [7:0] CH_T_UP   = 8'h54;
	localparam logic [7:0] CH_T_LOW  = 8'h74;
	localparam logic [7:0] CH_R_UP   = 8'h52;
	localparam logic [7:0] CH_R_LOW  = 8'h72;

	localparam logic [14:0] INT_MAX_PART = 15'h7FFF;

	localparam logic SRC_USB  = 1'b0;
	localparam logic SRC_UART = 1'b1;

	localparam logic [2:0] DEST_DESIRED  = 3'd0;
	localparam logic [2:0] DEST_THROTTLE = 3'd1;
	localparam logic [2:0] DEST_CURRENT  = 3'd2;
	localparam logic [2:0] DEST_UART_THR = 3'd3;
	localparam logic [2:0] DEST_ERROR    = 3'd4;

	typedef enum logic [2:0] {
		TK_DIGIT,
		TK_POINT,
		TK_MINUS,
		TK_OTHER,
		TK_TERM
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] character;
		logic       source;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         destination;
	} result_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] digit;
		logic [7:0] chr;
		logic       src;
	} token_t;

	// round(2^16 / 10^(idx+1))
	function automatic logic [12:0] frac_weight(input logic [2:0] idx);
		logic [12:0] w;
		unique case (idx)
			3'd0:    w = 13'd6554;
			3'd1:    w = 13'd655;
			3'd2:    w = 13'd66;
			3'd3:    w = 13'd7;
			3'd4:    w = 13'd1;
			default: w = 13'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/adcp_front.sv */
`default_nettype none

module adcp_front
	import adcp_pkg::*;
(
	input  item_t  item,
	output token_t tok
);

	always_comb begin
		tok.digit = item.character[3:0];
		tok.chr   = item.character;
		tok.src   = item.source;
		priority if (item.character == CH_NUL) begin
			tok.kind = TK_TERM;
		end else if (item.character >= CH_ZERO && item.character <= CH_NINE) begin
			tok.kind = TK_DIGIT;
		end else if (item.character == CH_POINT) begin
			tok.kind = TK_POINT;
		end else if (item.character == CH_MINUS) begin
			tok.kind = TK_MINUS;
		end else begin
			tok.kind = TK_OTHER;
		end
	end

endmodule

`default_nettype wire

/* rtl/adcp_tokq.sv */
`default_nettype none

module adcp_tokq
	import adcp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  token_t wr_tok,
	input  logic   rd_en,
	output token_t rd_tok,
	output logic   rd_valid,
	output logic   full
);

	token_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign rd_tok   = slot_q[rd_ptr_q];
	assign rd_valid = (cnt_q != 2'd0);
	assign full     = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/adcp_back.sv */
`default_nettype none

module adcp_back
	import adcp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  token_t  tok,
	input  logic    tok_valid,
	output logic    take,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	// frame state
	token_t      held_q;
	logic        held_valid_q;
	logic        neg_q;
	logic        in_frac_q;
	logic [14:0] int_q;
	logic [16:0] frac_q;
	logic [2:0]  fcnt_q;
	logic        bad_q;

	// result register
	logic        out_valid_q;
	result_t     res_q;

	logic        pop_ok;
	logic        is_term;
	logic        out_free;

	logic        neg_d;
	logic        in_frac_d;
	logic [14:0] int_d;
	logic [16:0] frac_d;
	logic [2:0]  fcnt_d;
	logic        bad_d;

	logic [18:0] int_next;
	logic [16:0] frac_prod;

	logic [2:0]  dest;
	logic [31:0] mag;
	logic [31:0] sat;
	logic [31:0] val;

	assign pop_ok   = pop && out_valid_q;
	assign is_term  = (tok.kind == TK_TERM);
	assign out_free = !out_valid_q || pop_ok;
	assign take     = tok_valid && (!is_term || out_free);
	assign empty    = !out_valid_q;
	assign result   = res_q;

	assign int_next  = 19'(int_q) * 19'd10 + 19'(held_q.digit);
	assign frac_prod = 17'(held_q.digit) * 17'(frac_weight(fcnt_q));

	// Parse the held character into the number state.
	always_comb begin
		neg_d     = neg_q;
		in_frac_d = in_frac_q;
		int_d     = int_q;
		frac_d    = frac_q;
		fcnt_d    = fcnt_q;
		bad_d     = bad_q;
		if (held_valid_q) begin
			unique case (held_q.kind)
				TK_DIGIT: begin
					if (!in_frac_q) begin
						int_d = (int_next > 19'(INT_MAX_PART)) ? INT_MAX_PART
							: int_next[14:0];
					end else if (fcnt_q < 3'(FRAC_LIMIT)) begin
						frac_d = frac_q + frac_prod;
						fcnt_d = fcnt_q + 3'd1;
					end
				end
				TK_POINT: begin
					if (in_frac_q) bad_d = 1'b1;
					else in_frac_d = 1'b1;
				end
				TK_MINUS: begin
					if (!neg_q && !in_frac_q && int_q == 15'd0) neg_d = 1'b1;
					else bad_d = 1'b1;
				end
				default: bad_d = 1'b1;
			endcase
		end
	end

	// Terminator: pick destination and build the value.
	always_comb begin
		dest = DEST_ERROR;
		if (held_valid_q && !bad_q) begin
			if (tok.src == SRC_USB) begin
				if (held_q.chr == CH_O_UP || held_q.chr == CH_O_LOW) dest = DEST_DESIRED;
				else if (held_q.chr == CH_T_UP || held_q.chr == CH_T_LOW) dest = DEST_THROTTLE;
			end else begin
				if (held_q.chr == CH_R_UP || held_q.chr == CH_R_LOW) dest = DEST_CURRENT;
				else if (held_q.chr == CH_T_UP || held_q.chr == CH_T_LOW) dest = DEST_UART_THR;
			end
		end
		mag = {1'b0, int_q, 16'h0000} + 32'(frac_q);
		sat = mag[31] ? 32'h7FFF_FFFF : mag;
		val = neg_q ? (32'd0 - sat) : sat;
		if (dest == DEST_ERROR) val = 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '{kind: TK_OTHER, digit: 4'd0, chr: CH_NUL, src: SRC_USB};
			held_valid_q <= 1'b0;
			neg_q        <= 1'b0;
			in_frac_q    <= 1'b0;
			int_q        <= '0;
			frac_q       <= '0;
			fcnt_q       <= '0;
			bad_q        <= 1'b0;
		end else if (take) begin
			if (is_term) begin
				held_valid_q <= 1'b0;
				neg_q        <= 1'b0;
				in_frac_q    <= 1'b0;
				int_q        <= '0;
				frac_q       <= '0;
				fcnt_q       <= '0;
				bad_q        <= 1'b0;
			end else begin
				held_q       <= tok;
				held_valid_q <= 1'b1;
				neg_q        <= neg_d;
				in_frac_q    <= in_frac_d;
				int_q        <= int_d;
				frac_q       <= frac_d;
				fcnt_q       <= fcnt_d;
				bad_q        <= bad_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && is_term) begin
			out_valid_q <= 1'b1;
		end else if (pop_ok) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_term) begin
			res_q.value       <= signed'(val);
			res_q.destination <= dest;
		end
	end

endmodule

`default_nettype wire

/* rtl/ascii_decimal_command_parser.sv */
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   ------------------------------------------
// item      push / full          item_t   : character[7:0], source
// result    pop / empty          result_t : value[31:0] (Q15.16), destination[2:0]
//
// One character transaction per cycle while results are popped; the back end retires one
// token a cycle from the two-entry token queue.
// A terminator's result passes the token queue and the result register before it shows on the result ports.
// When a result sits unpopped, the next terminator waits in the queue; the
// queue then fills and full rises. Plain characters never stall the back end.
// arst_n clears the queue, the frame state and the result valid flag.

module ascii_decimal_command_parser
	import adcp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	token_t front_tok;   // classified incoming character
	token_t q_tok;       // oldest queued token
	logic   q_valid;
	logic   q_take;
	logic   q_full;

	assign full = q_full;

	// Front: character class and digit value
	adcp_front u_front (
		.item (item),
		.tok  (front_tok)
	);

	// Token queue between front and back
	adcp_tokq u_tokq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push && !q_full),
		.wr_tok   (front_tok),
		.rd_en    (q_take),
		.rd_tok   (q_tok),
		.rd_valid (q_valid),
		.full     (q_full)
	);

	// Back: number accumulation, command decode, result register
	adcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (q_tok),
		.tok_valid (q_valid),
		.take      (q_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire

/* rtl/adcp_chk.sv */
`default_nettype none

module adcp_chk
	import adcp_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    push,
	input wire logic    full,
	input wire item_t   item,
	input wire logic    empty,
	input wire logic    pop,
	input wire result_t result
);

	// Nothing waits on the result side while in reset.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result pending during reset");

	// A waiting result holds until popped.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

	// Error results carry a zero value.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.destination == DEST_ERROR) |-> (result.value == 32'sd0))
		else $error("error result with nonzero value");

	// Destination codes stay within the defined set.
	a_dest_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.destination <= DEST_ERROR))
		else $error("destination code out of range");

endmodule

bind ascii_decimal_command_parser adcp_chk u_adcp_chk (.*);

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
	import adcp_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int ITEM_GOAL    = 400;
	// Result trails the terminator through the queue and result register; leave a little slack.
	localparam int TAIL_CYCLES  = 8;
	localparam int LIMIT_CYCLES = 100_000;

	typedef logic [7:0] char_q_t[$];

	// Frame parser model plus the queue of commands still owed by the DUT.
	class command_frame_model;
		result_t     pending_commands[$];
		int unsigned fault_count;

		logic [7:0]  held_char;
		bit          held_valid;
		bit          negative;
		bit          in_fraction;
		bit          malformed;
		logic [14:0] int_part;
		logic [16:0] frac_sum;
		int unsigned frac_cnt;
		int unsigned frac_weights[6] = '{6554, 655, 66, 7, 1, 0};

		function new();
			clear_frame();
		endfunction

		function void clear_frame();
			held_char   = CH_NUL;
			held_valid  = 1'b0;
			negative    = 1'b0;
			in_fraction = 1'b0;
			malformed   = 1'b0;
			int_part    = '0;
			frac_sum    = '0;
			frac_cnt    = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			fault_count++;
		endtask

		// One accepted character transaction.
		function void take_char(input item_t it);
			logic [7:0]  c;
			int unsigned n;
			logic [32:0] mag;
			result_t     r;
			if (it.character != CH_NUL) begin
				// The previous character is now known not to be the command letter.
				if (held_valid) begin
					c = held_char;
					if (c >= CH_ZERO && c <= CH_NINE) begin
						n = c - CH_ZERO;
						if (!in_fraction) begin
							n = int_part * 10 + n;
							int_part = (n > INT_MAX_PART) ? INT_MAX_PART : n[14:0];
						end else if (frac_cnt < FRAC_DIGITS && frac_cnt < 6) begin
							frac_sum = frac_sum + n * frac_weights[frac_cnt];
							frac_cnt++;
						end
					end else if (c == CH_POINT) begin
						if (in_fraction)
							malformed = 1'b1;
						else
							in_fraction = 1'b1;
					end else if (c == CH_MINUS) begin
						// Sign only up front; leading zeros are fine.
						if (!negative && !in_fraction && int_part == '0)
							negative = 1'b1;
						else
							malformed = 1'b1;
					end else begin
						malformed = 1'b1;
					end
				end
				held_char  = it.character;
				held_valid = 1'b1;
				return;
			end

			// Terminator: held char is the command letter.
			r.destination = DEST_ERROR;
			r.value       = '0;
			if (held_valid && !malformed) begin
				if (it.source == SRC_USB) begin
					if (held_char == CH_O_UP || held_char == CH_O_LOW)
						r.destination = DEST_DESIRED;
					else if (held_char == CH_T_UP || held_char == CH_T_LOW)
						r.destination = DEST_THROTTLE;
				end else begin
					if (held_char == CH_R_UP || held_char == CH_R_LOW)
						r.destination = DEST_CURRENT;
					else if (held_char == CH_T_UP || held_char == CH_T_LOW)
						r.destination = DEST_UART_THR;
				end
			end
			if (r.destination != DEST_ERROR) begin
				mag = {int_part, 16'h0000};
				mag = mag + frac_sum;
				if (mag > 33'h0_7FFF_FFFF)
					mag = 33'h0_7FFF_FFFF;
				r.value = mag[31:0];
				if (negative)
					r.value = -r.value;
			end
			pending_commands.push_back(r);
			clear_frame();
		endfunction

		// One accepted result transaction, against the oldest pending command.
		task check_command(input result_t got);
			result_t want;
			if (pending_commands.size() == 0) begin
				report($sformatf("unrequested result value=%0d destination=%0d",
					got.value, got.destination));
				return;
			end
			want = pending_commands.pop_front();
			if (got.value !== want.value)
				report($sformatf("value %0d, wanted %0d (destination %0d)",
					got.value, want.value, want.destination));
			if (got.destination !== want.destination)
				report($sformatf("destination %0d, wanted %0d",
					got.destination, want.destination));
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    push   = 1'b0;
	logic    pop    = 1'b0;
	item_t   item   = '0;
	logic    full;
	logic    empty;
	result_t result;

	// When set, neither side idles.
	bit          steady = 1'b0;
	int unsigned chars_sent = 0;

	command_frame_model model = new();

	ascii_decimal_command_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the DUT hangs.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("end of test: mismatches");
		$finish;
	end

	// Drive one character transaction. push stays high across back-to-back
	// transactions; it only drops when an idle cycle is taken or in wait_idle.
	task automatic send_char(input item_t it);
		while (!steady && $urandom_range(99) < 20) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		model.take_char(it);
		chars_sent++;
	endtask

	// Characters of the frame on random sources, then the terminator on src.
	task automatic send_frame(input char_q_t chars, input logic src);
		item_t it;
		foreach (chars[i]) begin
			it.character = chars[i];
			it.source    = 1'($urandom_range(1));
			send_char(it);
		end
		it.character = CH_NUL;
		it.source    = src;
		send_char(it);
	endtask

	// Hold off the sender until every owed command has come out.
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (model.pending_commands.size() != 0)
			@(posedge clk);
	endtask

	function automatic char_q_t text_bytes(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	// Mostly well-formed frames with random content; some get a stray
	// character, an extra point or minus, and some are pure noise.
	task automatic build_frame(output char_q_t f, output logic src);
		logic [7:0]  letters[6];
		int unsigned roll;
		int unsigned pos;
		letters = '{CH_O_UP, CH_O_LOW, CH_T_UP, CH_T_LOW, CH_R_UP, CH_R_LOW};
		f.delete();
		src  = 1'($urandom_range(1));
		roll = $urandom_range(99);
		if ($urandom_range(2) == 0)
			f.push_back(CH_MINUS);
		// Integer part: sometimes right at the saturation point, sometimes past it.
		if ($urandom_range(7) == 0)
			f = {f, text_bytes("32767")};
		else
			repeat ($urandom_range(6))
				f.push_back(CH_ZERO + 8'($urandom_range(9)));
		if ($urandom_range(1)) begin
			f.push_back(CH_POINT);
			repeat ($urandom_range(7))
				f.push_back(CH_ZERO + 8'($urandom_range(9)));
		end
		f.push_back(letters[$urandom_range(5)]);
		if (roll >= 90) begin
			f.delete();
			repeat ($urandom_range(8))
				f.push_back(8'($urandom_range(255, 1)));
		end else if (roll >= 75) begin
			pos = $urandom_range(f.size() - 1);
			case ($urandom_range(2))
				0: f.insert(pos, CH_POINT);
				1: f.insert(pos, CH_MINUS);
				default: f[pos] = 8'($urandom_range(255, 1));
			endcase
		end
	endtask

	// Result side: pop with random stalls, check what gets accepted.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				model.check_command(result);
			pop <= steady || ($urandom_range(99) >= 20);
		end
	end

	initial begin
		char_q_t frame;
		logic    src;

		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames.
		send_frame(text_bytes(""), SRC_USB);              // empty frame -> error
		send_frame(text_bytes("-T"), SRC_USB);            // sign only, value 0
		send_frame(text_bytes("-40000.9999o"), SRC_USB);  // saturated integer + overflow
		send_frame(text_bytes("0-5R"), SRC_UART);         // minus after leading zero
		send_frame(text_bytes("1..t"), SRC_UART);         // second point -> error
		send_frame(text_bytes("7r"), SRC_USB);            // letter not valid for USB
		wait_idle();

		// Random frames, with a long no-idle window in the middle.
		while (chars_sent < ITEM_GOAL) begin
			steady = (chars_sent >= 150 && chars_sent < 260);
			build_frame(frame, src);
			send_frame(frame, src);
			if (!steady && $urandom_range(9) == 0)
				wait_idle();
		end
		steady = 1'b0;

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (model.pending_commands.size() != 0)
			model.report($sformatf("%0d results never came",
				model.pending_commands.size()));
		if (model.fault_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* sim.f */
rtl/adcp_pkg.sv
rtl/adcp_front.sv
rtl/adcp_tokq.sv
rtl/adcp_back.sv
rtl/ascii_decimal_command_parser.sv
rtl/adcp_chk.sv
test/tb.sv
